// ===== src/sha1bsh_pkg.sv =====
`timescale 1ns / 1ps

package sha1bsh_pkg;

	// SHA-1 initial chaining values
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	// Round constants, one for each group of twenty rounds
	localparam logic [31:0] K_GRP0 = 32'h5A827999;
	localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [5:0] LEN_POS      = 6'd56;
	localparam logic [6:0] LAST_ROUND   = 7'd79;
	localparam int         BLOCK_BITS   = 512;
	localparam int         DIGEST_BITS  = 160;

	// Working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// Round constant for round 0..79
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K_GRP0;
		end else if (rnd < 7'd40) begin
			k = K_GRP1;
		end else if (rnd < 7'd60) begin
			k = K_GRP2;
		end else begin
			k = K_GRP3;
		end
		return k;
	endfunction

endpackage

// ===== src/sha1bsh_round.sv =====
`timescale 1ns / 1ps

module sha1bsh_round import sha1bsh_pkg::*; (
	input  work_t       cur,
	input  logic [31:0] w,
	input  logic [6:0]  rnd,
	output work_t       nxt
);

	logic [31:0] f;
	logic [31:0] t;

	// Select the boolean function for this round group
	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
		end
	end

	// One round: new a from the sum, rotate the rest down
	assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + round_k(rnd);

	always_comb begin
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== src/sha1_byte_stream_hasher_core.sv =====
`timescale 1ns / 1ps

// SHA-1 hasher over a byte stream.
// Input channel s_axis: one message byte per transfer in tdata, tuser high
// when that byte belongs to the message, tlast high on the item that ends the
// message (tuser low with tlast high ends a message without adding a byte).
// Output channel m_axis: one transfer per message with the 160-bit digest in
// tdata and the length overflow flag in tuser.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts the compression: 80 rounds at one round per cycle through a single
// round unit, then an add into the chaining words, during which s_axis_tready
// stays low. An end item then appends padding one byte per cycle (up to 64
// bytes, or up to 72 over two blocks when the length needs a second block),
// runs one or two compressions and loads the digest register once the output
// register is free or its digest is taken, raising m_axis_tvalid.
// The digest sits in an output register; the block returns to idle and takes
// new bytes while the receiver stalls, and only waits before loading the next
// digest if the previous one has not been taken yet.
// Reset clears the byte count, loads the initial chaining values and drops
// m_axis_tvalid; the block is ready as soon as reset is released.

module sha1_byte_stream_hasher_core import sha1bsh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tuser,  // [0] byte_valid
	input  logic                   s_axis_tlast,  // end_of_message
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [63:0] digest_words_a_b, [127:64] digest_words_c_d, [159:128] digest_word_e
	output logic [DIGEST_BITS-1:0] m_axis_tdata,
	output logic                   m_axis_tuser   // [0] length_overflow
);

	state_t state_q, state_d;

	logic [BLOCK_BITS-1:0] win_q;
	logic [5:0]            fill_q;
	logic [63:0]           bit_len_q;
	logic                  ovf_q;
	logic                  fin_q;
	logic                  mark_q;
	logic                  len_ok_q;
	logic                  last_blk_q;
	logic [6:0]            rnd_q;
	work_t                 h_q;
	work_t                 work_q;
	work_t                 work_nxt;
	logic [DIGEST_BITS-1:0] out_data_q;
	logic                  out_ovf_q;
	logic                  out_vld_q;

	logic                  accept;
	logic                  absorb;
	logic                  ins_en;
	logic [7:0]            ins_byte;
	logic                  emit;
	logic [64:0]           len_sum;
	logic [7:0]            len_byte;
	logic [31:0]           w_new;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign absorb  = accept && s_axis_tuser && !ovf_q;
	assign len_sum = {1'b0, bit_len_q} + 65'd8;
	assign len_byte = 8'(bit_len_q >> {~fill_q[2:0], 3'b000});

	// Next schedule word from the window taps
	assign w_new = {win_q[447:416] ^ win_q[255:224] ^ win_q[95:64] ^ win_q[511:480]}
		<< 1 | {31'd0, win_q[447] ^ win_q[255] ^ win_q[95] ^ win_q[511]};

	sha1bsh_round u_round (
		.cur (work_q),
		.w   (win_q[511:480]),
		.rnd (rnd_q),
		.nxt (work_nxt)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (absorb && fill_q == 6'd63) begin
						state_d = ST_ROUND;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == 6'd63) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (last_blk_q) begin
					state_d = ST_OUT;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		ins_en        = 1'b0;
		ins_byte      = s_axis_tdata;
		emit          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				ins_en        = absorb;
			end
			ST_PAD: begin
				ins_en = 1'b1;
				if (!mark_q) begin
					ins_byte = PAD_MARK;
				end else if (fill_q >= LEN_POS && len_ok_q) begin
					ins_byte = len_byte;
				end else begin
					ins_byte = 8'h00;
				end
			end
			ST_OUT: begin
				emit = !out_vld_q || m_axis_tready;
			end
			default: begin
				ins_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: counts, flags, chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			bit_len_q  <= '0;
			ovf_q      <= 1'b0;
			fin_q      <= 1'b0;
			mark_q     <= 1'b0;
			len_ok_q   <= 1'b0;
			last_blk_q <= 1'b0;
			rnd_q      <= '0;
			h_q        <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				fin_q <= s_axis_tlast;
			end
			// Count message bits and flag the wrap
			if (absorb) begin
				bit_len_q <= len_sum[63:0];
				if (len_sum[64]) begin
					ovf_q <= 1'b1;
				end
			end
			if (ins_en) begin
				fill_q <= fill_q + 6'd1;
			end
			// Track the padding mark and where the length may go
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q   <= 1'b1;
					len_ok_q <= (fill_q < LEN_POS);
				end
			end
			if (state_d == ST_ROUND && state_q != ST_ROUND) begin
				last_blk_q <= (state_q == ST_PAD) && mark_q && len_ok_q;
				rnd_q      <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end
			// Fold the working variables into the chaining words
			if (state_q == ST_ADD) begin
				h_q.a <= h_q.a + work_q.a;
				h_q.b <= h_q.b + work_q.b;
				h_q.c <= h_q.c + work_q.c;
				h_q.d <= h_q.d + work_q.d;
				h_q.e <= h_q.e + work_q.e;
				if (!last_blk_q && mark_q) begin
					len_ok_q <= 1'b1;
				end
			end
			// Hand off the digest and restart the message
			if (emit) begin
				out_vld_q <= 1'b1;
				fill_q    <= '0;
				bit_len_q <= '0;
				ovf_q     <= 1'b0;
				fin_q     <= 1'b0;
				mark_q    <= 1'b0;
				len_ok_q  <= 1'b0;
				h_q       <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
			end else if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Block window: bytes shift in, then words shift out during the rounds
	always_ff @(posedge clk) begin
		if (ins_en) begin
			win_q <= {win_q[BLOCK_BITS-9:0], ins_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[BLOCK_BITS-33:0], w_new};
		end
	end

	// Working variables: load at block start, advance one round per cycle
	always_ff @(posedge clk) begin
		if (state_q != ST_ROUND) begin
			work_q <= h_q;
		end else begin
			work_q <= work_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {h_q.e, h_q.c, h_q.d, h_q.a, h_q.b};
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule
